@@ hdl/mdfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-delimiter frame detector package
// Register map, event codes and default parameter values shared by the
// frame detector.
// ----------------------------------------------------------------------------
package mdfd_pkg;

  localparam int NUM_PAIRS_DEF   = 2;
  localparam int MAX_PATTERN_DEF = 4;
  localparam int LENGTH_BITS_DEF = 12;

  localparam int REG_PAIRS     = 2;
  localparam int PAT_W         = 32;
  localparam int PAT_LEN_W     = 3;
  localparam int MAX_LEN_W     = 12;
  localparam int FRAME_LEN_W   = 12;
  localparam int APB_ADDR_W    = 5;
  localparam int APB_DATA_W    = 32;

  typedef enum logic [2:0] {
    REG_ACTIVE_SEQ  = 3'd0,
    REG_START_PAT_0 = 3'd1,
    REG_START_PAT_1 = 3'd2,
    REG_END_PAT_0   = 3'd3,
    REG_END_PAT_1   = 3'd4,
    REG_PAT_LENGTHS = 3'd5,
    REG_MAX_LEN_0   = 3'd6,
    REG_MAX_LEN_1   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_START   = 2'd1,
    EVT_FRAME   = 2'd2,
    EVT_DISCARD = 2'd3
  } event_e;

endpackage

@@ hdl/multi_delimiter_frame_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-delimiter frame detector
// Hunts a byte stream for configured start patterns, then for the matching
// end pattern, and reports start, frame complete or overlength discard.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Word
//  in      | sink      | in_valid_i/in_stall_o  | data_byte_i
//  out     | source    | out_valid_o/out_stall_i| event, pair, length, flag, byte
//  cfg     | slave     | APB psel/penable       | 32-bit register write/read
//
// One word is taken per cycle; each result appears in the cycle after its word.
// The single result register sets the rate: a new word enters whenever that
// register is empty or being taken in the same cycle.
// Reset clears the history, the hunt state and all configuration registers to defaults.
// A stall on the output stalls the input once the result register is full.
// ----------------------------------------------------------------------------
module multi_delimiter_frame_detector #(
  parameter int NUM_PAIRS   = mdfd_pkg::NUM_PAIRS_DEF,
  parameter int MAX_PATTERN = mdfd_pkg::MAX_PATTERN_DEF,
  parameter int LENGTH_BITS = mdfd_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mdfd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mdfd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mdfd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      data_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      event_res_o,
  output logic                            pair_index_o,
  output logic [mdfd_pkg::FRAME_LEN_W-1:0] frame_length_o,
  output logic                            in_frame_o,
  output logic [7:0]                      data_out_o
);

  localparam int HW    = 8 * MAX_PATTERN;
  localparam int FW    = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W = (LENGTH_BITS > mdfd_pkg::MAX_LEN_W) ? LENGTH_BITS
                                                               : mdfd_pkg::MAX_LEN_W;
  localparam logic [LENGTH_BITS-1:0] LEN_MASK = '1;
  localparam logic [mdfd_pkg::PAT_LEN_W-1:0] MAX_PAT_LEN =
      mdfd_pkg::PAT_LEN_W'(MAX_PATTERN);
  localparam logic [1:0] NUM_PAIRS_V = 2'(NUM_PAIRS);

  logic                              cfg_wr;
  logic [1:0]                        active_q;
  logic [mdfd_pkg::PAT_W-1:0]        start_pat_q [mdfd_pkg::REG_PAIRS];
  logic [mdfd_pkg::PAT_W-1:0]        end_pat_q   [mdfd_pkg::REG_PAIRS];
  logic [7:0]                        plen_q;
  logic [mdfd_pkg::MAX_LEN_W-1:0]    max_len_q   [mdfd_pkg::REG_PAIRS];

  logic [HW-1:0]                     hist_q, hist_d;
  logic [FW-1:0]                     fill_q, fill_d, fill_inc;
  logic                              collecting_q, collecting_d;
  logic                              pair_q, pair_d;
  logic [LENGTH_BITS-1:0]            count_q, count_d, count_inc;

  logic                              in_acc;
  logic                              out_valid_q;
  mdfd_pkg::event_e                  evt;
  logic                              evt_pair;
  logic [LENGTH_BITS-1:0]            evt_len;
  logic                              evt_inf;
  mdfd_pkg::event_e                  event_q;
  logic                              pair_out_q;
  logic [mdfd_pkg::FRAME_LEN_W-1:0]  len_out_q;
  logic                              inf_out_q;
  logic [7:0]                        data_out_q;

  logic [1:0]                        n_active;
  logic                              found;
  logic [mdfd_pkg::PAT_LEN_W-1:0]    start_len;
  logic [LENGTH_BITS-1:0]            start_limit;
  logic [LENGTH_BITS-1:0]            cur_limit;
  logic [mdfd_pkg::PAT_LEN_W-1:0]    end_len;

  function automatic logic [mdfd_pkg::PAT_LEN_W-1:0] pat_len(input logic [1:0] field);
    logic [mdfd_pkg::PAT_LEN_W-1:0] n;
    n = mdfd_pkg::PAT_LEN_W'(field) + 1'b1;
    return (n > MAX_PAT_LEN) ? MAX_PAT_LEN : n;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] limit_of(
      input logic [mdfd_pkg::MAX_LEN_W-1:0] max_len);
    logic [CMP_W-1:0] m;
    m = CMP_W'(max_len);
    return (m > CMP_W'(LEN_MASK)) ? LEN_MASK : LENGTH_BITS'(m);
  endfunction

  function automatic logic tail_match(input logic [HW-1:0] hist,
                                      input logic [FW-1:0] fill,
                                      input logic [mdfd_pkg::PAT_W-1:0] pat,
                                      input logic [mdfd_pkg::PAT_LEN_W-1:0] len);
    logic ok;
    ok = (mdfd_pkg::PAT_LEN_W'(fill) >= len);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if ((mdfd_pkg::PAT_LEN_W'(k) < len) && (hist[8*k +: 8] != pat[8*k +: 8])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 2'd1;
      start_pat_q  <= '{default: '0};
      end_pat_q    <= '{default: '0};
      plen_q       <= '0;
      max_len_q    <= '{default: '1};
    end else if (cfg_wr) begin
      case (mdfd_pkg::cfg_reg_e'(paddr[4:2]))
        mdfd_pkg::REG_ACTIVE_SEQ:  active_q     <= pwdata[1:0];
        mdfd_pkg::REG_START_PAT_0: start_pat_q[0] <= pwdata;
        mdfd_pkg::REG_START_PAT_1: start_pat_q[1] <= pwdata;
        mdfd_pkg::REG_END_PAT_0:   end_pat_q[0] <= pwdata;
        mdfd_pkg::REG_END_PAT_1:   end_pat_q[1] <= pwdata;
        mdfd_pkg::REG_PAT_LENGTHS: plen_q       <= pwdata[7:0];
        mdfd_pkg::REG_MAX_LEN_0:   max_len_q[0] <= pwdata[mdfd_pkg::MAX_LEN_W-1:0];
        mdfd_pkg::REG_MAX_LEN_1:   max_len_q[1] <= pwdata[mdfd_pkg::MAX_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (mdfd_pkg::cfg_reg_e'(paddr[4:2]))
      mdfd_pkg::REG_ACTIVE_SEQ:  prdata = 32'(active_q);
      mdfd_pkg::REG_START_PAT_0: prdata = start_pat_q[0];
      mdfd_pkg::REG_START_PAT_1: prdata = start_pat_q[1];
      mdfd_pkg::REG_END_PAT_0:   prdata = end_pat_q[0];
      mdfd_pkg::REG_END_PAT_1:   prdata = end_pat_q[1];
      mdfd_pkg::REG_PAT_LENGTHS: prdata = 32'(plen_q);
      mdfd_pkg::REG_MAX_LEN_0:   prdata = 32'(max_len_q[0]);
      mdfd_pkg::REG_MAX_LEN_1:   prdata = 32'(max_len_q[1]);
      default:                   prdata = '0;
    endcase
  end

  // Handshake: the result register frees up when it is empty or being taken.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Byte history, newest byte in the low lane.
  always_comb begin
    hist_d[7:0] = data_byte_i;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      hist_d[8*k +: 8] = hist_q[8*(k-1) +: 8];
    end
  end

  assign fill_inc  = (fill_q < FW'(MAX_PATTERN)) ? fill_q + 1'b1 : fill_q;
  assign count_inc = (count_q != LEN_MASK) ? count_q + 1'b1 : count_q;
  assign n_active  = (active_q == 2'd0) ? 2'd1 :
                     (active_q > NUM_PAIRS_V) ? NUM_PAIRS_V : active_q;
  assign cur_limit = limit_of(pair_q ? max_len_q[1] : max_len_q[0]);
  assign end_len   = pat_len(pair_q ? plen_q[7:6] : plen_q[3:2]);

  always_comb begin
    evt          = mdfd_pkg::EVT_NONE;
    evt_pair     = 1'b0;
    evt_len      = '0;
    evt_inf      = 1'b0;
    fill_d       = fill_inc;
    collecting_d = collecting_q;
    pair_d       = pair_q;
    count_d      = count_q;
    found        = 1'b0;
    start_len    = '0;
    start_limit  = '0;
    if (!collecting_q) begin
      for (int i = 0; i < NUM_PAIRS; i++) begin
        if (!found && (2'(i) < n_active) &&
            tail_match(hist_d, fill_inc, start_pat_q[i], pat_len(plen_q[4*i +: 2]))) begin
          found       = 1'b1;
          start_len   = pat_len(plen_q[4*i +: 2]);
          start_limit = limit_of(max_len_q[i]);
          evt_pair    = 1'(i);
        end
      end
      if (found) begin
        fill_d = '0;
        if (LENGTH_BITS'(start_len) >= start_limit) begin
          evt = mdfd_pkg::EVT_DISCARD;
        end else begin
          evt          = mdfd_pkg::EVT_START;
          evt_inf      = 1'b1;
          collecting_d = 1'b1;
          pair_d       = evt_pair;
          count_d      = LENGTH_BITS'(start_len);
        end
      end
    end else begin
      evt_pair = pair_q;
      count_d  = count_inc;
      if (tail_match(hist_d, fill_inc, pair_q ? end_pat_q[1] : end_pat_q[0], end_len)) begin
        evt          = mdfd_pkg::EVT_FRAME;
        evt_inf      = 1'b1;
        evt_len      = count_inc;
        collecting_d = 1'b0;
        fill_d       = '0;
      end else if (count_inc >= cur_limit) begin
        evt          = mdfd_pkg::EVT_DISCARD;
        collecting_d = 1'b0;
        fill_d       = '0;
      end else begin
        evt_inf = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q       <= '0;
      fill_q       <= '0;
      collecting_q <= 1'b0;
      pair_q       <= 1'b0;
      count_q      <= '0;
    end else if (in_acc) begin
      hist_q       <= hist_d;
      fill_q       <= fill_d;
      collecting_q <= collecting_d;
      pair_q       <= pair_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      event_q    <= evt;
      pair_out_q <= evt_pair;
      len_out_q  <= mdfd_pkg::FRAME_LEN_W'(evt_len);
      inf_out_q  <= evt_inf;
      data_out_q <= data_byte_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = event_q;
  assign pair_index_o   = pair_out_q;
  assign frame_length_o = len_out_q;
  assign in_frame_o     = inf_out_q;
  assign data_out_o     = data_out_q;

  a_discard_not_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o == mdfd_pkg::EVT_DISCARD)) |-> !in_frame_o)
    else $error("discard result flagged as in frame");

  a_length_only_on_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o != mdfd_pkg::EVT_FRAME)) |-> (frame_length_o == '0))
    else $error("frame length reported without frame complete");

  a_collect_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(collecting_q) |-> $past(in_acc && (evt == mdfd_pkg::EVT_START)))
    else $error("collection began without a start event");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    collecting_q |-> (count_q != '0))
    else $error("frame count is zero while collecting");

endmodule

@@ test/multi_delimiter_frame_detector_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-delimiter frame detector checker
// Watches the register port and both word channels of the frame detector,
// predicts the result of every accepted input word from its own copy of the
// registers and the hunt state, and compares each accepted result word field
// by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module multi_delimiter_frame_detector_checker
  import mdfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [1:0]            event_res_i,
  input  logic                  pair_index_i,
  input  logic [FRAME_LEN_W-1:0] frame_length_i,
  input  logic                  in_frame_i,
  input  logic [7:0]            data_out_i,
  output int                    mismatch_count_o,
  output int                    words_pending_o
);

  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    event_e                 evt;
    logic                   pair;
    logic [FRAME_LEN_W-1:0] length;
    logic                   in_frame;
    logic [7:0]             data;
  } detect_result_t;

  logic [7:0]       history [4];
  int unsigned      history_fill;
  logic             collecting;
  logic             frame_pair;
  logic [11:0]      frame_bytes;

  logic [1:0]       pair_setting;
  logic [31:0]      start_pat [2];
  logic [31:0]      end_pat [2];
  logic [7:0]       pat_lengths;
  logic [11:0]      max_len [2];

  detect_result_t   expected_q [$];
  detect_result_t   oldest;
  int               errors = 0;

  assign mismatch_count_o = errors;

  function automatic int unsigned pattern_bytes(input int unsigned slot);
    return pat_lengths[2*slot +: 2] + 1;
  endfunction

  function automatic bit history_ends_with(input logic [31:0] pat, input int unsigned len);
    if (history_fill < len) return 1'b0;
    for (int k = 0; k < len; k++) begin
      if (history[k] != pat[8*k +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void store_register(input cfg_reg_e idx, input logic [31:0] value);
    case (idx)
      REG_ACTIVE_SEQ:  pair_setting = value[1:0];
      REG_START_PAT_0: start_pat[0] = value;
      REG_START_PAT_1: start_pat[1] = value;
      REG_END_PAT_0:   end_pat[0] = value;
      REG_END_PAT_1:   end_pat[1] = value;
      REG_PAT_LENGTHS: pat_lengths = value[7:0];
      REG_MAX_LEN_0:   max_len[0] = value[11:0];
      REG_MAX_LEN_1:   max_len[1] = value[11:0];
      default: ;
    endcase
  endfunction

  function automatic detect_result_t next_result(input logic [7:0] b);
    detect_result_t r;
    int unsigned    pairs;
    int unsigned    slen;
    r.evt      = EVT_NONE;
    r.pair     = 1'b0;
    r.length   = '0;
    r.in_frame = 1'b0;
    r.data     = b;
    for (int k = 3; k > 0; k--) history[k] = history[k-1];
    history[0] = b;
    if (history_fill < 4) history_fill++;
    if (!collecting) begin
      pairs = (pair_setting == 2'd0) ? 1 : ((pair_setting > 2'd2) ? 2 : pair_setting);
      for (int i = 0; i < pairs; i++) begin
        slen = pattern_bytes(2*i);
        if (history_ends_with(start_pat[i], slen)) begin
          r.pair = 1'(i);
          history_fill = 0;
          if (slen >= max_len[i]) begin
            r.evt = EVT_DISCARD;
          end else begin
            r.evt       = EVT_START;
            r.in_frame  = 1'b1;
            collecting  = 1'b1;
            frame_pair  = 1'(i);
            frame_bytes = 12'(slen);
          end
          break;
        end
      end
    end else begin
      r.pair = frame_pair;
      if (frame_bytes < 12'hFFF) frame_bytes++;
      if (history_ends_with(end_pat[frame_pair], pattern_bytes(2*frame_pair + 1))) begin
        r.evt        = EVT_FRAME;
        r.in_frame   = 1'b1;
        r.length     = frame_bytes;
        collecting   = 1'b0;
        history_fill = 0;
      end else if (frame_bytes >= max_len[frame_pair]) begin
        r.evt        = EVT_DISCARD;
        collecting   = 1'b0;
        history_fill = 0;
      end else begin
        r.in_frame = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      history         = '{default: 8'h00};
      history_fill    = 0;
      collecting      = 1'b0;
      frame_pair      = 1'b0;
      frame_bytes     = '0;
      pair_setting    = 2'd1;
      start_pat       = '{default: 32'h0};
      end_pat         = '{default: 32'h0};
      pat_lengths     = 8'h00;
      max_len         = '{default: 12'd4095};
      expected_q.delete();
      words_pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        store_register(cfg_reg_e'(paddr[APB_ADDR_W-1:2]), pwdata);
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(next_result(data_byte_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) $error("result word arrived with none expected");
        end else begin
          oldest = expected_q.pop_front();
          compare_field("event_res", oldest.evt, event_res_i);
          compare_field("pair_index", oldest.pair, pair_index_i);
          compare_field("frame_length", oldest.length, frame_length_i);
          compare_field("in_frame", oldest.in_frame, in_frame_i);
          compare_field("data_out", oldest.data, data_out_i);
        end
      end
      words_pending_o <= expected_q.size();
    end
  end

endmodule

@@ test/multi_delimiter_frame_detector_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-delimiter frame detector testbench
// Drives byte words into the frame detector under random input gaps and
// output stalls. A directed opening covers reset settings, pair priority,
// frame completion, overlength discard and the pair count limits; random
// phases then reprogram every register and send mostly well-formed frames
// mixed with cut frames and noise. The checker beside the block predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module multi_delimiter_frame_detector_test;
  import mdfd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 105;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr       = '0;
  logic [APB_DATA_W-1:0]  pwdata      = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [7:0]             data_byte_i = 8'h00;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [1:0]             event_res_o;
  logic                   pair_index_o;
  logic [FRAME_LEN_W-1:0] frame_length_o;
  logic                   in_frame_o;
  logic [7:0]             data_out_o;

  int mismatch_count;
  int words_pending;
  int words_sent  = 0;
  int cycle_count = 0;
  bit steady_input = 1'b0;

  logic [1:0]  pair_setting = 2'd1;
  logic [31:0] start_pat [2] = '{default: 32'h0};
  logic [31:0] end_pat [2]   = '{default: 32'h0};
  logic [7:0]  pat_lengths   = 8'h00;
  logic [11:0] max_len [2]   = '{default: 12'd4095};

  multi_delimiter_frame_detector i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .pair_index_o   (pair_index_o),
    .frame_length_o (frame_length_o),
    .in_frame_o     (in_frame_o),
    .data_out_o     (data_out_o)
  );

  multi_delimiter_frame_detector_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_res_i      (event_res_o),
    .pair_index_i     (pair_index_o),
    .frame_length_i   (frame_length_o),
    .in_frame_i       (in_frame_o),
    .data_out_i       (data_out_o),
    .mismatch_count_o (mismatch_count),
    .words_pending_o  (words_pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pattern_bytes(input int slot);
    return pat_lengths[2*slot +: 2] + 1;
  endfunction

  function automatic logic [7:0] noise_byte();
    int          sel;
    int          pos;
    logic [31:0] pat;
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    sel = $urandom_range(0, 3);
    pos = $urandom_range(0, 3);
    pat = (sel < 2) ? start_pat[sel] : end_pat[sel-2];
    return pat[8*pos +: 8];
  endfunction

  function automatic logic [11:0] random_max();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 12'd4095;
    if (r < 25) return 12'($urandom_range(0, 2));
    return 12'($urandom_range(3, 24));
  endfunction

  task automatic write_register(input cfg_reg_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ACTIVE_SEQ:  pair_setting = value[1:0];
      REG_START_PAT_0: start_pat[0] = value;
      REG_START_PAT_1: start_pat[1] = value;
      REG_END_PAT_0:   end_pat[0] = value;
      REG_END_PAT_1:   end_pat[1] = value;
      REG_PAT_LENGTHS: pat_lengths = value[7:0];
      REG_MAX_LEN_0:   max_len[0] = value[11:0];
      REG_MAX_LEN_1:   max_len[1] = value[11:0];
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [7:0] b);
    int gap;
    gap = steady_input ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic send_sequence(input logic [7:0] seq [$]);
    foreach (seq[i]) send_word(seq[i]);
  endtask

  task automatic send_pattern(input logic [31:0] pat, input int len);
    for (int j = len - 1; j >= 0; j--) send_word(pat[8*j +: 8]);
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_word(noise_byte());
  endtask

  task automatic end_phase();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (words_pending != 0);
  endtask

  task automatic setup_phase(input int phase);
    int          r;
    logic [1:0]  act;
    logic [11:0] m0;
    logic [11:0] m1;
    r = $urandom_range(0, 9);
    if (phase < 2) act = 2'd2;
    else if (phase == 3) act = 2'd3;
    else if (phase == 4) act = 2'd0;
    else act = (r == 0) ? 2'd0 : (r == 1) ? 2'd1 : (r == 2) ? 2'd3 : 2'd2;
    if (phase == 0) begin
      m0 = 12'd4095;
      m1 = 12'd4095;
    end else if (phase == 1) begin
      m0 = 12'd0;
      m1 = 12'd1;
    end else begin
      m0 = random_max();
      m1 = random_max();
    end
    write_register(REG_ACTIVE_SEQ, act);
    write_register(REG_START_PAT_0, $urandom);
    write_register(REG_START_PAT_1, $urandom);
    write_register(REG_END_PAT_0, $urandom);
    write_register(REG_END_PAT_1, $urandom);
    write_register(REG_PAT_LENGTHS, $urandom_range(0, 255));
    write_register(REG_MAX_LEN_0, m0);
    write_register(REG_MAX_LEN_1, m1);
    steady_input = ($urandom_range(0, 3) == 0);
  endtask

  task automatic run_phase(input int quota);
    int stop;
    int kind;
    int p;
    int n;
    int pairs;
    stop  = words_sent + quota;
    pairs = (pair_setting >= 2'd2) ? 2 : 1;
    while (words_sent < stop) begin
      kind = $urandom_range(0, 99);
      p    = $urandom_range(0, pairs - 1);
      if (kind < 70) begin
        send_noise($urandom_range(0, 2));
        send_pattern(start_pat[p], pattern_bytes(2*p));
        n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 30);
        send_noise(n);
        send_pattern(end_pat[p], pattern_bytes(2*p + 1));
      end else if (kind < 85) begin
        send_pattern(start_pat[p], pattern_bytes(2*p));
        n = max_len[p] + $urandom_range(0, 3);
        if (n > 40) n = $urandom_range(20, 40);
        send_noise(n);
        send_word(end_pat[p][7:0]);
      end else begin
        send_noise($urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    int run;
    int hold;
    forever begin
      out_stall_i <= 1'b0;
      run = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) : $urandom_range(20, 120);
      repeat (run) @(posedge clk_i);
      hold = idle_cycles();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("multi_delimiter_frame_detector: mismatch");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With the reset settings one zero byte opens a frame and the next closes it.
    send_sequence('{8'h00, 8'h00, 8'hFF});
    end_phase();

    // Both pairs can start on 5A; pair 0 must win the tie.
    write_register(REG_ACTIVE_SEQ, 32'd2);
    write_register(REG_START_PAT_0, 32'h0000A55A);
    write_register(REG_START_PAT_1, 32'h0000005A);
    write_register(REG_END_PAT_0, 32'h00000D0A);
    write_register(REG_END_PAT_1, 32'h000000FF);
    write_register(REG_PAT_LENGTHS, 32'h00000005);
    write_register(REG_MAX_LEN_0, 32'd6);
    write_register(REG_MAX_LEN_1, 32'd3);
    send_sequence('{8'hA5, 8'h5A, 8'h11, 8'h0D, 8'h0A, 8'h5A, 8'h00, 8'hFF, 8'h5A,
                    8'h01, 8'h02, 8'hA5, 8'h5A, 8'h01, 8'h02, 8'h03, 8'h04});
    end_phase();

    // A pair count of zero leaves only pair 0, whose start alone reaches the limit.
    write_register(REG_ACTIVE_SEQ, 32'd0);
    write_register(REG_MAX_LEN_0, 32'd2);
    send_sequence('{8'hA5, 8'h5A, 8'h5A, 8'hFF});
    end_phase();

    for (int phase = 0; phase < PHASES; phase++) begin
      setup_phase(phase);
      run_phase(PHASE_WORDS);
      end_phase();
    end

    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("multi_delimiter_frame_detector: match");
    end else begin
      $display("multi_delimiter_frame_detector: mismatch");
    end
    $finish;
  end

endmodule
